>>> hw/rtl/sma_pkg.sv
`timescale 1ns / 1ps
package sma_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ActW = 3;
  localparam int unsigned DepthW = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4,
    ACT_SQRT = 3'd5,
    ACT_NOP6 = 3'd6,
    ACT_NOP7 = 3'd7
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_NEGROOT = 3'd4
  } status_e;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_BIN,
    OP_SQRT
  } op_e;

  typedef struct packed {
    op_e                 op;
    action_e             action;
    logic [DataW-1:0]    push_value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_ITER,
    S_WRITE,
    S_OUT
  } state_e;

endpackage

>>> hw/rtl/sma_if.sv
`timescale 1ns / 1ps
interface sma_in_if;
  logic                        valid;
  logic                        ready;
  logic [sma_pkg::ActW-1:0]    action;
  logic signed [sma_pkg::DataW-1:0] push_value;
  modport source (output valid, action, push_value, input ready);
  modport sink (input valid, action, push_value, output ready);
endinterface

interface sma_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sma_pkg::DataW-1:0] top_value;
  logic [sma_pkg::DepthW-1:0]       depth;
  logic [sma_pkg::StatusW-1:0]      status;
  modport source (output valid, top_value, depth, status, input ready);
  modport sink (input valid, top_value, depth, status, output ready);
endinterface

>>> hw/rtl/sma_front.sv
`timescale 1ns / 1ps
module sma_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  sma_in_if.sink      in_if,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output sma_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(sma_pkg::QueueDepth);

  sma_pkg::cmd_t            mem_q [sma_pkg::QueueDepth];
  logic [PtrW-1:0]          wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]            cnt_q, cnt_d;
  sma_pkg::cmd_t            cmd_in;
  logic                     push, pop;

  always_comb begin
    cmd_in.action = sma_pkg::action_e'(in_if.action);
    cmd_in.push_value = in_if.push_value;
    unique case (sma_pkg::action_e'(in_if.action))
      sma_pkg::ACT_PUSH: cmd_in.op = sma_pkg::OP_PUSH;
      sma_pkg::ACT_ADD, sma_pkg::ACT_SUB, sma_pkg::ACT_MUL,
      sma_pkg::ACT_DIV: cmd_in.op = sma_pkg::OP_BIN;
      sma_pkg::ACT_SQRT: cmd_in.op = sma_pkg::OP_SQRT;
      default: cmd_in.op = sma_pkg::OP_NONE;
    endcase
  end

  assign in_if.ready = (cnt_q != (PtrW+1)'(sma_pkg::QueueDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = mem_q[rd_q];
  assign push = in_if.valid && in_if.ready;
  assign pop = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

>>> hw/rtl/sma_back.sv
`timescale 1ns / 1ps
module sma_back #(
  parameter int unsigned STACK_DEPTH = sma_pkg::StackDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  sma_pkg::cmd_t cmd_i,
  sma_out_if.source     out_if
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W = sma_pkg::DataW;
  localparam int unsigned StepW = $clog2(W + 1);

  logic [W-1:0]       mem_q [STACK_DEPTH];
  logic [W-1:0]       rd_data_q;
  logic [AddrW-1:0]   rd_addr;
  logic               rd_en;
  logic [AddrW-1:0]   wr_addr;
  logic               wr_en;
  logic [W-1:0]       wr_data;

  sma_pkg::state_e    state_q, state_d;
  sma_pkg::cmd_t      cmd_q, cmd_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [W-1:0]       top_q, top_d;
  logic [W-1:0]       below_q, below_d;
  logic [W-1:0]       res_q, res_d;
  logic [W-1:0]       rem_q, rem_d;
  logic [W-1:0]       quo_q, quo_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               neg_q, neg_d;
  logic [sma_pkg::StatusW-1:0] st_q, st_d;
  logic               ov_q, ov_d;
  logic [W-1:0]       otop_q, otop_d;
  logic [sma_pkg::DepthW-1:0] odep_q, odep_d;
  logic [sma_pkg::StatusW-1:0] ost_q, ost_d;

  logic [W-1:0]       mag_top, mag_below;
  logic [W:0]         trial;
  logic [W+1:0]       sq_trial;
  logic [W-1:0]       prod;
  logic [W-1:0]       sq_rem2;

  assign mag_top = top_q[W-1] ? (W)'(0) - top_q : top_q;
  assign mag_below = below_q[W-1] ? (W)'(0) - below_q : below_q;
  assign prod = below_q * top_q;
  // divide step: shift remainder left by one dividend bit
  assign trial = {rem_q, quo_q[W-1]} - {1'b0, mag_top};
  // root step: two radicand bits per cycle; remainder in rem_q, radicand in quo_q
  assign sq_rem2 = quo_q;
  assign sq_trial = {rem_q, sq_rem2[W-1:W-2]} - {res_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    top_d = top_q;
    below_d = below_q;
    res_d = res_q;
    rem_d = rem_q;
    quo_d = quo_q;
    step_d = step_q;
    neg_d = neg_q;
    st_d = st_q;
    ov_d = ov_q;
    otop_d = otop_q;
    odep_d = odep_q;
    ost_d = ost_q;
    cmd_ready_o = 1'b0;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = res_q;
    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      sma_pkg::S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          st_d = sma_pkg::ST_OK;
          unique case (cmd_i.op)
            sma_pkg::OP_PUSH: begin
              if (cnt_q == CntW'(STACK_DEPTH)) begin
                st_d = sma_pkg::ST_OVER;
                state_d = sma_pkg::S_OUT;
              end else begin
                wr_en = 1'b1;
                wr_addr = cnt_q[AddrW-1:0];
                wr_data = cmd_i.push_value;
                top_d = cmd_i.push_value;
                cnt_d = cnt_q + 1'b1;
                state_d = sma_pkg::S_OUT;
              end
            end
            sma_pkg::OP_BIN: begin
              if (cnt_q < CntW'(2)) begin
                st_d = sma_pkg::ST_UNDER;
                state_d = sma_pkg::S_OUT;
              end else begin
                rd_en = 1'b1;
                rd_addr = AddrW'(cnt_q - CntW'(2));
                state_d = sma_pkg::S_READ;
              end
            end
            sma_pkg::OP_SQRT: begin
              if (cnt_q == '0) begin
                st_d = sma_pkg::ST_UNDER;
              end else if (top_q[W-1]) begin
                st_d = sma_pkg::ST_NEGROOT;
              end else begin
                quo_d = top_q;
                rem_d = '0;
                res_d = '0;
                step_d = StepW'(W / 2);
                state_d = sma_pkg::S_ITER;
              end
              if (state_d != sma_pkg::S_ITER) begin
                state_d = sma_pkg::S_OUT;
              end
            end
            default: state_d = sma_pkg::S_OUT;
          endcase
        end
      end
      sma_pkg::S_READ: begin
        below_d = rd_data_q;
        state_d = sma_pkg::S_EXEC;
      end
      sma_pkg::S_EXEC: begin
        res_d = res_q;
        priority case (cmd_q.action)
          sma_pkg::ACT_ADD: res_d = below_q + top_q;
          sma_pkg::ACT_SUB: res_d = below_q - top_q;
          sma_pkg::ACT_MUL: res_d = prod;
          default: ;
        endcase
        if (cmd_q.action == sma_pkg::ACT_DIV) begin
          if (top_q == '0) begin
            st_d = sma_pkg::ST_DIVZ;
            state_d = sma_pkg::S_OUT;
          end else begin
            quo_d = mag_below;
            rem_d = '0;
            neg_d = below_q[W-1] ^ top_q[W-1];
            step_d = StepW'(W);
            state_d = sma_pkg::S_ITER;
          end
        end else begin
          state_d = sma_pkg::S_WRITE;
        end
      end
      sma_pkg::S_ITER: begin
        if (cmd_q.op == sma_pkg::OP_SQRT) begin
          if (!sq_trial[W+1]) begin
            rem_d = sq_trial[W-1:0];
            res_d = {res_q[W-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[W-3:0], sq_rem2[W-1:W-2]};
            res_d = {res_q[W-2:0], 1'b0};
          end
          quo_d = {quo_q[W-3:0], 2'b00};
        end else begin
          if (!trial[W]) begin
            rem_d = trial[W-1:0];
            quo_d = {quo_q[W-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[W-2:0], quo_q[W-1]};
            quo_d = {quo_q[W-2:0], 1'b0};
          end
        end
        step_d = step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          state_d = sma_pkg::S_WRITE;
        end
        if (step_q == StepW'(1) && cmd_q.op != sma_pkg::OP_SQRT) begin
          res_d = neg_q ? (W)'(0) - quo_d : quo_d;
        end
      end
      sma_pkg::S_WRITE: begin
        wr_en = 1'b1;
        top_d = res_q;
        wr_data = res_q;
        if (cmd_q.op == sma_pkg::OP_SQRT) begin
          wr_addr = AddrW'(cnt_q - 1'b1);
        end else begin
          wr_addr = AddrW'(cnt_q - CntW'(2));
          cnt_d = cnt_q - 1'b1;
        end
        state_d = sma_pkg::S_OUT;
      end
      sma_pkg::S_OUT: begin
        if (!ov_q || out_if.ready) begin
          ov_d = 1'b1;
          otop_d = (cnt_q == '0) ? '0 : top_q;
          odep_d = sma_pkg::DepthW'(cnt_q);
          ost_d = st_q;
          // top_q already holds the top after a pop
          state_d = sma_pkg::S_IDLE;
        end
      end
      default: state_d = sma_pkg::S_IDLE;
    endcase
  end

  assign out_if.valid = ov_q;
  assign out_if.top_value = otop_q;
  assign out_if.depth = odep_q;
  assign out_if.status = ost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sma_pkg::S_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    top_q <= top_d;
    below_q <= below_d;
    res_q <= res_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    step_q <= step_d;
    neg_q <= neg_d;
    st_q <= st_d;
    otop_q <= otop_d;
    odep_q <= odep_d;
    ost_q <= ost_d;
  end

endmodule

>>> hw/rtl/stack_machine_alu_unit.sv
`timescale 1ns / 1ps
// Stack machine arithmetic unit.
// in_if carries one action per beat (push, add, subtract, multiply, divide,
// square root); out_if returns one beat per action with the new top of
// stack, the depth and a status code. Both use valid/ready.
// A two-entry command queue sits behind in_if, so up to two actions are
// taken while the execution side is busy or the output is stalled.
// Divide produces one quotient bit per cycle by shift and subtract;
// square root produces one root bit per cycle.
// One action executes at a time; the stack memory read port and the
// iterative unit set how long each action takes.
// The result register holds its beat until out_if.ready; the back end then
// waits and the queue fills, after which in_if.ready drops.
// Reset empties the stack and the queue; stack contents are not cleared,
// only entries below the depth count are ever read.
module stack_machine_alu_unit #(
  parameter int unsigned STACK_DEPTH = sma_pkg::StackDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sma_in_if.sink    in_if,
  sma_out_if.source out_if
);

  logic          cmd_valid;
  logic          cmd_ready;
  sma_pkg::cmd_t cmd;

  sma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sma_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_if      (out_if)
  );

endmodule
